>>> src/idq_pkg.sv
// Shared types and constants for the input-restricted deque.
`default_nettype none

package idq_pkg;

  // Default number of record slots in the ring buffer.
  localparam int unsigned DepthDef = 16;

  // Width of one record field, and of a stored record {id, salary}.
  localparam int unsigned FieldW = 32;
  localparam int unsigned RecW   = 2 * FieldW;

  // Operation codes carried by an input word.
  typedef enum logic [1:0] {
    OP_INS_REAR = 2'd0,
    OP_DEL_FRONT = 2'd1,
    OP_DEL_REAR = 2'd2,
    OP_DISPLAY = 2'd3
  } op_e;

  // Status codes carried by a result word.
  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Controller state.
  typedef enum logic {
    CS_IDLE,
    CS_DISP
  } ctrl_state_e;

  // Result load request from the controller to the output register.
  typedef struct packed {
    logic    load;
    logic    from_mem;
    status_e status;
    logic    last;
  } res_t;

  // Memory access strobes from the controller.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_req_t;

endpackage

`default_nettype wire

>>> src/idq_mem.sv
// Record store: synchronous single-write, single-read memory with registered read data.
`default_nettype none

module idq_mem #(
  parameter int unsigned DEPTH = idq_pkg::DepthDef,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk_i,
  input  wire idq_pkg::mem_req_t       req_i,
  input  wire logic [AW-1:0]           wr_addr_i,
  input  wire logic [idq_pkg::RecW-1:0] wr_data_i,
  input  wire logic [AW-1:0]           rd_addr_i,
  output logic [idq_pkg::RecW-1:0]     rd_data_o
);
  import idq_pkg::*;

  logic [RecW-1:0] mem_q [DEPTH];
  logic [RecW-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> src/idq_ctrl.sv
// Deque controller: pointers, entry count, display sequencer and memory access.
`default_nettype none

module idq_ctrl #(
  parameter int unsigned DEPTH = idq_pkg::DepthDef,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire idq_pkg::op_e      opcode_i,
  input  wire logic              out_free_i,
  output logic                   in_stall_o,
  output idq_pkg::mem_req_t      mem_req_o,
  output logic [AW-1:0]          wr_addr_o,
  output logic [AW-1:0]          rd_addr_o,
  output idq_pkg::res_t          res_o
);
  import idq_pkg::*;

  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] Full    = CW'(DEPTH);

  ctrl_state_e   state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          rd_pend_q, rd_pend_d;
  logic          rd_last_q, rd_last_d;

  logic          can_go;
  logic          accept;
  logic          empty;
  logic [AW-1:0] head_nx;
  logic [AW-1:0] tail_nx;
  logic [AW-1:0] tail_pv;
  logic [AW-1:0] idx_nx;

  // Ring pointer stepping modulo DEPTH.
  assign head_nx = (head_q == LastIdx) ? '0 : head_q + 1'b1;
  assign tail_nx = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
  assign tail_pv = (tail_q == '0) ? LastIdx : tail_q - 1'b1;
  assign idx_nx  = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;

  // A new step may start only when no read is in flight and the output word is free.
  assign can_go = out_free_i && !rd_pend_q;
  assign empty  = (count_q == '0);
  assign accept = (state_q == CS_IDLE) && in_valid_i && can_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= CS_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      rem_q     <= '0;
      rd_pend_q <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      rem_q     <= rem_d;
      rd_pend_q <= rd_pend_d;
      rd_last_q <= rd_last_d;
    end
  end

  // Next state, pointer updates and memory requests.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    idx_d     = idx_q;
    rem_d     = rem_q;
    rd_pend_d = 1'b0;
    rd_last_d = rd_last_q;
    mem_req_o = '0;
    wr_addr_o = tail_q;
    rd_addr_o = head_q;
    in_stall_o = !((state_q == CS_IDLE) && can_go);

    // Read data landing this cycle goes to the output word.
    res_o.load     = rd_pend_q;
    res_o.from_mem = 1'b1;
    res_o.status   = ST_OK;
    res_o.last     = rd_last_q;

    case (state_q)
      CS_IDLE: begin
        if (accept) begin
          res_o.from_mem = 1'b0;
          res_o.last     = 1'b1;
          case (opcode_i)
            OP_INS_REAR: begin
              res_o.load = 1'b1;
              if (count_q == Full) begin
                res_o.status = ST_FULL;
              end else begin
                mem_req_o.wr_en = 1'b1;
                tail_d  = tail_nx;
                count_d = count_q + 1'b1;
              end
            end
            OP_DEL_FRONT: begin
              if (empty) begin
                res_o.load   = 1'b1;
                res_o.status = ST_EMPTY;
              end else begin
                mem_req_o.rd_en = 1'b1;
                rd_pend_d = 1'b1;
                rd_last_d = 1'b1;
                head_d    = head_nx;
                count_d   = count_q - 1'b1;
              end
            end
            OP_DEL_REAR: begin
              if (empty) begin
                res_o.load   = 1'b1;
                res_o.status = ST_EMPTY;
              end else begin
                mem_req_o.rd_en = 1'b1;
                rd_addr_o = tail_pv;
                rd_pend_d = 1'b1;
                rd_last_d = 1'b1;
                tail_d    = tail_pv;
                count_d   = count_q - 1'b1;
              end
            end
            default: begin
              if (empty) begin
                res_o.load   = 1'b1;
                res_o.status = ST_EMPTY;
              end else begin
                mem_req_o.rd_en = 1'b1;
                rd_pend_d = 1'b1;
                rd_last_d = (count_q == CW'(1));
                idx_d     = head_nx;
                rem_d     = count_q - 1'b1;
                if (count_q != CW'(1)) begin
                  state_d = CS_DISP;
                end
              end
            end
          endcase
        end
      end
      CS_DISP: begin
        // One read per free output slot, front to rear.
        if (can_go) begin
          mem_req_o.rd_en = 1'b1;
          rd_addr_o = idx_q;
          rd_pend_d = 1'b1;
          rd_last_d = (rem_q == CW'(1));
          idx_d     = idx_nx;
          rem_d     = rem_q - 1'b1;
          if (rem_q == CW'(1)) begin
            state_d = CS_IDLE;
          end
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  // The entry count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= Full)
    else $error("entry count above capacity");

  // While displaying there is always at least one record left to read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CS_DISP) |-> (rem_q != '0))
    else $error("display sequencer with nothing left");

  // A read in flight keeps the input side stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_pend_q |-> in_stall_o)
    else $error("input taken while a read is in flight");

  // The pointers stay consistent with the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == tail_q))
    else $error("empty deque with unequal pointers");

endmodule

`default_nettype wire

>>> src/input_restricted_deque_core.sv
// Insert and empty/full results go to the output register on acceptance; delete and display
// results first pass the registered memory read. Insert takes one word per cycle while the
// output word is free; a read in flight stalls input and the next display read.
// Reset (rst_ni low, asynchronous) empties the deque and the output register.
// Memory contents are not cleared; only written slots are ever read.
`default_nettype none

module input_restricted_deque_core #(
  parameter int unsigned DEPTH = idq_pkg::DepthDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire idq_pkg::op_e                    opcode_i,
  input  wire logic signed [idq_pkg::FieldW-1:0] rec_id_i,
  input  wire logic signed [idq_pkg::FieldW-1:0] rec_salary_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output idq_pkg::status_e                     status_o,
  output logic signed [idq_pkg::FieldW-1:0]    out_id_o,
  output logic signed [idq_pkg::FieldW-1:0]    out_salary_o,
  output logic                                 last_o
);
  import idq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mem_req_t        mem_req;
  logic [AW-1:0]   wr_addr;
  logic [AW-1:0]   rd_addr;
  logic [RecW-1:0] rd_data;
  res_t            res;
  logic            out_free;

  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  logic [FieldW-1:0] id_q, id_d;
  logic [FieldW-1:0] sal_q, sal_d;
  logic            last_q, last_d;

  assign out_free = !out_valid_q || !out_stall_i;

  idq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .out_free_i (out_free),
    .in_stall_o (in_stall_o),
    .mem_req_o  (mem_req),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr),
    .res_o      (res)
  );

  idq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .wr_addr_i (wr_addr),
    .wr_data_i ({rec_id_i, rec_salary_i}),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Output word register.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    id_d        = id_q;
    sal_d       = sal_q;
    last_d      = last_q;
    if (res.load) begin
      out_valid_d = 1'b1;
      status_d    = res.status;
      last_d      = res.last;
      id_d        = res.from_mem ? rd_data[RecW-1:FieldW] : '0;
      sal_d       = res.from_mem ? rd_data[FieldW-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    id_q     <= id_d;
    sal_q    <= sal_d;
    last_q   <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign out_id_o     = id_q;
  assign out_salary_o = sal_q;
  assign last_o       = last_q;

  // A new result is loaded only when the output word is free or being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res.load |-> out_free)
    else $error("result loaded over a pending output word");

  // A memory read is followed by a result load in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) mem_req.rd_en |=> res.load)
    else $error("read data not delivered");

  // Memory is never read and written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.rd_en && mem_req.wr_en))
    else $error("overlapping memory read and write");

endmodule

`default_nettype wire
